FILE: hdl/fdr_pkg.sv
// Shared types and constants for the dielectric Fresnel reflectance pipeline.
// No dependencies.
`timescale 1ns / 1ps
package fdr_pkg;

	localparam int unsigned COS_W      = 16;
	localparam int unsigned IDX_W      = 14;
	localparam int unsigned SQ_IDX_W   = 2 * IDX_W;
	localparam int unsigned RAD_W      = 58;
	localparam int unsigned ROOT_W     = RAD_W / 2;
	localparam int unsigned A_W        = IDX_W + COS_W;
	localparam int unsigned NUM_W      = 44;
	localparam int unsigned Q_W        = 32;
	localparam int unsigned SQRT_STEPS = ROOT_W;
	localparam int unsigned DIV_STEPS  = Q_W;
	localparam logic [Q_W-1:0] ONE_Q31 = 32'h8000_0000;

	typedef struct packed {
		logic [A_W-1:0]      a;
		logic [IDX_W-1:0]    n1;
		logic [SQ_IDX_W-1:0] n2sq;
		logic [COS_W-1:0]    c;
		logic                tir;
	} fdr_side_t;

endpackage

FILE: hdl/fdr_sqrt.sv
// Pipelined digit-by-digit integer square root, one result bit per stage.
// Carries the per-item side data alongside. Depends on fdr_pkg.
`timescale 1ns / 1ps
module fdr_sqrt import fdr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  logic [RAD_W-1:0]  rad,
	input  fdr_side_t         side_in,
	output logic              out_v,
	output logic [ROOT_W-1:0] root,
	output fdr_side_t         side_out
);

	logic              v_s    [SQRT_STEPS];
	logic [ROOT_W+1:0] rem_s  [SQRT_STEPS];
	logic [ROOT_W-1:0] root_s [SQRT_STEPS];
	logic [RAD_W-1:0]  rad_s  [SQRT_STEPS];
	fdr_side_t         side_s [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_stage
		logic              pv;
		logic [ROOT_W+1:0] prem;
		logic [ROOT_W-1:0] proot;
		logic [RAD_W-1:0]  prad;
		fdr_side_t         pside;
		logic [ROOT_W+2:0] rem_w;
		logic [ROOT_W+2:0] trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign pv    = in_v;
			assign prem  = '0;
			assign proot = '0;
			assign prad  = rad;
			assign pside = side_in;
		end else begin : g_next
			assign pv    = v_s[k-1];
			assign prem  = rem_s[k-1];
			assign proot = root_s[k-1];
			assign prad  = rad_s[k-1];
			assign pside = side_s[k-1];
		end

		assign rem_w = {prem[ROOT_W:0], prad[RAD_W-1:RAD_W-2]};
		assign trial = {1'b0, proot, 2'b01};
		assign ge    = (rem_w >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? (ROOT_W+2)'(rem_w - trial) : rem_w[ROOT_W+1:0];
				root_s[k] <= {proot[ROOT_W-2:0], ge};
				rad_s[k]  <= {prad[RAD_W-3:0], 2'b00};
				side_s[k] <= pside;
			end
		end
	end

	assign out_v    = v_s[SQRT_STEPS-1];
	assign root     = root_s[SQRT_STEPS-1];
	assign side_out = side_s[SQRT_STEPS-1];

endmodule

FILE: hdl/fdr_div.sv
// Two-lane pipelined restoring divider giving truncated Q31 ratios num/den.
// A zero divisor yields 1.0. Depends on fdr_pkg.
`timescale 1ns / 1ps
module fdr_div import fdr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_v,
	input  logic [NUM_W-1:0] num_s,
	input  logic [NUM_W-1:0] den_s,
	input  logic [NUM_W-1:0] num_p,
	input  logic [NUM_W-1:0] den_p,
	input  logic             tir_in,
	output logic             out_v,
	output logic [Q_W-1:0]   q_s,
	output logic [Q_W-1:0]   q_p,
	output logic             tir_out
);

	typedef struct packed {
		logic [NUM_W-1:0] r;
		logic [NUM_W-1:0] den;
		logic [Q_W-1:0]   q;
		logic             zero;
	} div_lane_t;

	function automatic div_lane_t div_step(div_lane_t cur, logic [NUM_W:0] t);
		div_lane_t nx;
		logic      ge;
		ge   = (t >= {1'b0, cur.den});
		nx   = cur;
		nx.r = ge ? NUM_W'(t - {1'b0, cur.den}) : t[NUM_W-1:0];
		nx.q = {cur.q[Q_W-2:0], ge};
		return nx;
	endfunction

	logic      v_s   [DIV_STEPS];
	div_lane_t ls_s  [DIV_STEPS];
	div_lane_t lp_s  [DIV_STEPS];
	logic      tir_s [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
		logic          pv;
		logic          ptir;
		div_lane_t     pls;
		div_lane_t     plp;
		logic [NUM_W:0] ts;
		logic [NUM_W:0] tp;

		if (k == 0) begin : g_first
			assign pv   = in_v;
			assign ptir = tir_in;
			assign pls  = '{r: '0, den: den_s, q: '0, zero: (den_s == '0)};
			assign plp  = '{r: '0, den: den_p, q: '0, zero: (den_p == '0)};
			assign ts   = {1'b0, num_s};
			assign tp   = {1'b0, num_p};
		end else begin : g_next
			assign pv   = v_s[k-1];
			assign ptir = tir_s[k-1];
			assign pls  = ls_s[k-1];
			assign plp  = lp_s[k-1];
			assign ts   = {ls_s[k-1].r, 1'b0};
			assign tp   = {lp_s[k-1].r, 1'b0};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ls_s[k]  <= div_step(pls, ts);
				lp_s[k]  <= div_step(plp, tp);
				tir_s[k] <= ptir;
			end
		end
	end

	assign out_v   = v_s[DIV_STEPS-1];
	assign q_s     = ls_s[DIV_STEPS-1].zero ? ONE_Q31 : ls_s[DIV_STEPS-1].q;
	assign q_p     = lp_s[DIV_STEPS-1].zero ? ONE_Q31 : lp_s[DIV_STEPS-1].q;
	assign tir_out = tir_s[DIV_STEPS-1];

endmodule

FILE: hdl/fresnel_dielectric_reflectance_top.sv
// Unpolarized dielectric Fresnel reflectance, fully pipelined.
// Accepts one word per cycle while the result is not stalled.
// The square root (29 stages) and the two-lane divider (32 stages) set the depth.
// A stalled result freezes every stage; nothing is dropped or repeated.
// arst_n clears all stage valid bits; data registers are not reset.
// Depends on fdr_pkg, fdr_sqrt, fdr_div.
`timescale 1ns / 1ps
module fresnel_dielectric_reflectance_top import fdr_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [COS_W-1:0] cos_incident,
	input  logic [IDX_W-1:0]        index_inside,
	input  logic [IDX_W-1:0]        index_outside,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [15:0]             reflectance,
	output logic                    total_reflection
);

	logic en;
	logic v_s70;

	assign en       = !(v_s70 && out_stall);
	assign in_stall = v_s70 && out_stall;

	// stage 1: pick side, fold sign
	logic                entering;
	logic [COS_W-1:0]    c_abs;
	logic                v_s1;
	logic [COS_W-1:0]    c_s1;
	logic [IDX_W-1:0]    n1_s1, n2_s1;

	assign entering = (cos_incident != '0) && !cos_incident[COS_W-1];
	assign c_abs    = cos_incident[COS_W-1] ? COS_W'(-cos_incident) : cos_incident;

	// stage 2
	logic                v_s2;
	logic [2*COS_W-1:0]  cc_s2;
	logic [SQ_IDX_W-1:0] n1sq_s2, n2sq_s2;
	logic [COS_W-1:0]    c_s2;
	logic [IDX_W-1:0]    n1_s2;

	// stage 3
	logic                v_s3;
	logic [30:0]         s_s3;
	logic [A_W-1:0]      a_s3;
	logic [SQ_IDX_W-1:0] n1sq_s3, n2sq_s3;
	logic [COS_W-1:0]    c_s3;
	logic [IDX_W-1:0]    n1_s3;

	// stage 4
	logic                v_s4;
	logic [RAD_W:0]      sub_s4;
	logic [A_W-1:0]      a_s4;
	logic [SQ_IDX_W-1:0] n2sq_s4;
	logic [COS_W-1:0]    c_s4;
	logic [IDX_W-1:0]    n1_s4;

	// stage 5
	logic [RAD_W-1:0]    big;
	logic                tir;
	logic                v_s5;
	logic [RAD_W-1:0]    rad_s5;
	fdr_side_t           side_s5;

	assign big = {n2sq_s4, 30'd0};
	assign tir = (sub_s4 > {1'b0, big});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1    <= c_abs;
			n1_s1   <= entering ? index_outside : index_inside;
			n2_s1   <= entering ? index_inside : index_outside;

			cc_s2   <= c_s1 * c_s1;
			n1sq_s2 <= n1_s1 * n1_s1;
			n2sq_s2 <= n2_s1 * n2_s1;
			c_s2    <= c_s1;
			n1_s2   <= n1_s1;

			s_s3    <= 31'(32'h4000_0000 - cc_s2);
			a_s3    <= n1_s2 * c_s2;
			n1sq_s3 <= n1sq_s2;
			n2sq_s3 <= n2sq_s2;
			c_s3    <= c_s2;
			n1_s3   <= n1_s2;

			sub_s4  <= n1sq_s3 * s_s3;
			a_s4    <= a_s3;
			n2sq_s4 <= n2sq_s3;
			c_s4    <= c_s3;
			n1_s4   <= n1_s3;

			rad_s5  <= RAD_W'(big - sub_s4[RAD_W-1:0]);
			side_s5 <= '{a: a_s4, n1: n1_s4, n2sq: n2sq_s4, c: c_s4, tir: tir};
		end
	end

	// stages 6 to 34: transmitted cosine times n2
	logic              sq_v;
	logic [ROOT_W-1:0] m;
	fdr_side_t         sq_side;

	fdr_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s5),
		.rad      (rad_s5),
		.side_in  (side_s5),
		.out_v    (sq_v),
		.root     (m),
		.side_out (sq_side)
	);

	// stage 35
	logic             v_s35;
	logic [NUM_W-2:0] nm_s35;
	logic [NUM_W-1:0] b_s35;
	logic [A_W-1:0]   a_s35;
	logic [A_W-1:0]   m_s35;
	logic             tir_s35;

	// stage 36
	logic             v_s36;
	logic [NUM_W-1:0] num_s_s36, den_s_s36, num_p_s36, den_p_s36;
	logic             tir_s36;

	logic [NUM_W-1:0] nm_x;

	assign nm_x = {1'b0, nm_s35};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s35 <= 1'b0;
			v_s36 <= 1'b0;
		end else if (en) begin
			v_s35 <= sq_v;
			v_s36 <= v_s35;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nm_s35    <= sq_side.n1 * m;
			b_s35     <= sq_side.n2sq * sq_side.c;
			a_s35     <= sq_side.a;
			m_s35     <= A_W'(m);
			tir_s35   <= sq_side.tir;

			num_s_s36 <= NUM_W'((a_s35 >= m_s35) ? (a_s35 - m_s35) : (m_s35 - a_s35));
			den_s_s36 <= NUM_W'({1'b0, a_s35} + {1'b0, m_s35});
			num_p_s36 <= (b_s35 >= nm_x) ? (b_s35 - nm_x) : (nm_x - b_s35);
			den_p_s36 <= b_s35 + nm_x;
			tir_s36   <= tir_s35;
		end
	end

	// stages 37 to 68: amplitude ratios
	logic           dv;
	logic [Q_W-1:0] qs, qp;
	logic           dtir;

	fdr_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (v_s36),
		.num_s   (num_s_s36),
		.den_s   (den_s_s36),
		.num_p   (num_p_s36),
		.den_p   (den_p_s36),
		.tir_in  (tir_s36),
		.out_v   (dv),
		.q_s     (qs),
		.q_p     (qp),
		.tir_out (dtir)
	);

	// stage 69: square, stage 70: sum, round, saturate
	logic             v_s69;
	logic [2*Q_W-1:0] sqs_s69, sqp_s69;
	logic             tir_s69;

	logic [2*Q_W:0]   sum;
	logic [17:0]      r;

	assign sum = {1'b0, sqs_s69} + {1'b0, sqp_s69};
	assign r   = 18'((sum + ((2*Q_W+1)'(1) << 46)) >> 47);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s69 <= 1'b0;
			v_s70 <= 1'b0;
		end else if (en) begin
			v_s69 <= dv;
			v_s70 <= v_s69;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqs_s69          <= qs * qs;
			sqp_s69          <= qp * qp;
			tir_s69          <= dtir;

			total_reflection <= tir_s69;
			if (tir_s69 || (r > 18'd65535) || sum[2*Q_W]) begin
				reflectance <= 16'hFFFF;
			end else begin
				reflectance <= r[15:0];
			end
		end
	end

	assign out_valid = v_s70;

endmodule

FILE: tb/tb_top.sv
// Testbench for the dielectric Fresnel reflectance pipeline: drives incident cosine and
// index pairs, predicts reflectance and total reflection with its own integer model.
// Depends on fdr_pkg and fresnel_dielectric_reflectance_top.
`timescale 1ns / 1ps
module tb_top;
	import fdr_pkg::*;

	typedef struct packed {
		logic [15:0] refl;
		logic        tir;
	} refl_word_t;

	localparam longint CYCLE_LIMIT = 400000;

	logic                    clk = 0;
	logic                    arst_n = 0;
	logic                    in_valid = 0;
	logic                    in_stall;
	logic signed [COS_W-1:0] cos_incident = '0;
	logic [IDX_W-1:0]        index_inside = '0;
	logic [IDX_W-1:0]        index_outside = '0;
	logic                    out_valid;
	logic                    out_stall = 0;
	logic [15:0]             reflectance;
	logic                    total_reflection;

	refl_word_t expected_q[$];
	int     errors = 0;
	int     words_checked = 0;
	int     tir_seen = 0;
	int     rx_gap = 0;
	longint cycles = 0;
	bit     rx_idle_on = 1;
	bit     tx_idle_on = 1;
	bit     hold_rx = 0;

	fresnel_dielectric_reflectance_top dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] amp_q31(logic [63:0] x, logic [63:0] y);
		logic [63:0] num, den, q, r;
		num = (x >= y) ? x - y : y - x;
		den = x + y;
		if (den == 0)
			return 64'd1 << 31;
		q = (num >= den) ? 1 : 0;
		r = num - q * den;
		for (int i = 0; i < 31; i++) begin
			r <<= 1;
			q <<= 1;
			if (r >= den) begin
				r -= den;
				q |= 1;
			end
		end
		return q;
	endfunction

	function automatic refl_word_t fresnel_predict(logic [15:0] raw, logic [13:0] n_in,
			logic [13:0] n_out);
		refl_word_t  w;
		bit          entering;
		logic [63:0] c, n1, n2, s, big, sub, m, qs, qp, sum, r;
		entering = (raw != 0) && !raw[15];
		c = raw[15] ? 64'h10000 - raw : raw;
		n1 = entering ? n_out : n_in;
		n2 = entering ? n_in : n_out;
		s = (64'd1 << 30) - c * c;
		big = (n2 * n2) << 30;
		sub = n1 * n1 * s;
		if (sub > big) begin
			w.refl = 16'hFFFF;
			w.tir = 1;
			return w;
		end
		m = int_sqrt(big - sub);
		qs = amp_q31(n1 * c, m);
		qp = amp_q31(n2 * n2 * c, n1 * m);
		sum = qs * qs + qp * qp;
		r = (sum + (64'd1 << 46)) >> 47;
		w.refl = (r > 65535) ? 16'hFFFF : r[15:0];
		w.tir = 0;
		return w;
	endfunction

	// valid stays high between back-to-back words; drop it only while idling
	task automatic send_word(logic [15:0] cv, logic [13:0] ni, logic [13:0] no);
		if (tx_idle_on && $urandom_range(0, 9) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid <= 1;
		cos_incident <= cv;
		index_inside <= ni;
		index_outside <= no;
		expected_q.push_back(fresnel_predict(cv, ni, no));
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_random(int count, bit near_one);
		logic [13:0] ni, no;
		for (int i = 0; i < count; i++) begin
			ni = near_one ? 14'($urandom_range(4096, 12288)) : 14'($urandom_range(0, 16383));
			no = near_one ? 14'($urandom_range(4096, 12288)) : 14'($urandom_range(0, 16383));
			send_word(16'($urandom), ni, no);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (expected_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_directed();
		logic [15:0] cosv[7] = '{16'h7FFF, 16'h8001, 16'h8000, 16'h0000, 16'h0001,
				16'hFFFF, 16'h4000};
		foreach (cosv[i]) begin
			send_word(cosv[i], 14'd6144, 14'd4096);
			send_word(cosv[i], 14'd4096, 14'd6144);
		end
		send_word(16'h2000, 14'h3FFF, 14'h0000);
		send_word(16'hE000, 14'h0000, 14'h3FFF);
		send_word(16'h0000, 14'h0000, 14'h0000);
		send_word(16'h7FFF, 14'h3FFF, 14'h3FFF);
		send_word(16'h8000, 14'h2AAA, 14'h1555);
		send_word(16'h1234, 14'h1000, 14'h1000);
		wait_drained();
	endtask

	task automatic test_random_mix();
		send_random(700, 1);
		send_random(300, 0);
	endtask

	// hold results off for a long stretch so the pipeline fills and backs up
	task automatic test_backpressure();
		fork
			begin
				hold_rx = 1;
				repeat (150) @(negedge clk);
				hold_rx = 0;
			end
			send_random(200, 1);
		join
		wait_drained();
	endtask

	task automatic test_full_rate();
		rx_idle_on = 0;
		tx_idle_on = 0;
		send_random(300, 1);
	endtask

	always @(negedge clk) begin
		if (hold_rx) begin
			out_stall <= 1;
		end else if (rx_gap > 0) begin
			out_stall <= 1;
			rx_gap--;
		end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
			out_stall <= 1;
			rx_gap = $urandom_range(0, 4);
		end else begin
			out_stall <= 0;
		end
	end

	always @(posedge clk) begin
		refl_word_t e;
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("unexpected word: reflectance %0d", reflectance);
				errors++;
			end else begin
				e = expected_q.pop_front();
				words_checked++;
				if (e.tir)
					tir_seen++;
				if (reflectance !== e.refl) begin
					$error("reflectance: expected %0d actual %0d", e.refl, reflectance);
					errors++;
				end
				if (total_reflection !== e.tir) begin
					$error("total_reflection: expected %0d actual %0d", e.tir,
							total_reflection);
					errors++;
				end
			end
		end
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("timeout after %0d cycles", cycles);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_directed();
		test_random_mix();
		test_backpressure();
		test_full_rate();
		wait_drained();
		repeat (100) @(negedge clk);
		$display("checked %0d words, %0d with total internal reflection,", words_checked,
				tir_seen);
		$display("covering edge cosines, extreme indices, backpressure and full rate");
		if (errors == 0 && expected_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
